// ===== design/polyline_window_clipper_unit_assert.svh =====
// Assertion macros shared by the clipper checker.
// Depends on nothing; included by bare file name.
`ifndef POLYLINE_WINDOW_CLIPPER_UNIT_ASSERT_SVH
`define POLYLINE_WINDOW_CLIPPER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PWC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pwc checker: property failed");

// Next-cycle implication, disabled during reset.
`define PWC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pwc checker: property failed");

`endif

// ===== design/pwc_pkg.sv =====
// Shared types, widths and helpers for the polyline window clipper.
// Depends on nothing.
package pwc_pkg;

  localparam int COORD_BITS = 16;
  localparam int WIN_W      = 16;
  localparam int SIZE_W     = 15;
  localparam int EXT_W      = ((COORD_BITS > WIN_W) ? COORD_BITS : WIN_W) + 2;
  localparam int D_W        = COORD_BITS + 1;
  localparam int DIFF_W     = EXT_W + 1;
  localparam int DM_W       = COORD_BITS;
  localparam int DFM_W      = EXT_W;
  localparam int DVD_W      = DM_W + DFM_W;
  localparam int T_W        = DVD_W + 2;
  localparam int CNT_W      = $clog2(DVD_W + 1);

  localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(480);

  localparam int RG_LEFT  = 0;
  localparam int RG_RIGHT = 1;
  localparam int RG_ABOVE = 2;
  localparam int RG_BELOW = 3;

  typedef enum logic [1:0] {
    CFG_WIN_LEFT,
    CFG_WIN_TOP,
    CFG_WIN_WIDTH,
    CFG_WIN_HEIGHT
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_EDGE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_CHECK,
    S_EMIT
  } pwc_state_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

  function automatic logic [3:0] region_of(
    input logic signed [EXT_W-1:0] x,
    input logic signed [EXT_W-1:0] y,
    input logic signed [EXT_W-1:0] xmin,
    input logic signed [EXT_W-1:0] xmax,
    input logic signed [EXT_W-1:0] ymin,
    input logic signed [EXT_W-1:0] ymax
  );
    logic [3:0] r;
    r = '0;
    if (x < xmin) r[RG_LEFT] = 1'b1;
    else if (x > xmax) r[RG_RIGHT] = 1'b1;
    if (y < ymin) r[RG_ABOVE] = 1'b1;
    else if (y > ymax) r[RG_BELOW] = 1'b1;
    return r;
  endfunction

endpackage

// ===== design/pwc_in_if.sv =====
// Vertex input channel: valid/ready with the vertex payload.
// Depends on pwc_pkg.
interface pwc_in_if import pwc_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pt_x;
  logic signed [COORD_BITS-1:0] pt_y;
  logic                         first_point;
  modport source (output valid, pt_x, pt_y, first_point, input ready);
  modport sink (input valid, pt_x, pt_y, first_point, output ready);
endinterface

// ===== design/pwc_out_if.sv =====
// Segment result channel: valid/ready with the clipped segment.
// Depends on pwc_pkg.
interface pwc_out_if import pwc_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] seg_x0;
  logic signed [COORD_BITS-1:0] seg_y0;
  logic signed [COORD_BITS-1:0] seg_x1;
  logic signed [COORD_BITS-1:0] seg_y1;
  modport source (output valid, seg_x0, seg_y0, seg_x1, seg_y1, input ready);
  modport sink (input valid, seg_x0, seg_y0, seg_x1, seg_y1, output ready);
endinterface

// ===== design/pwc_cfg_if.sv =====
// Configuration write channel: valid/ready, register index and data.
// Depends on pwc_pkg.
interface pwc_cfg_if import pwc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       index;
  logic [WIN_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/pwc_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pwc_pkg.
module pwc_div import pwc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  div_ctl_t         ctl_in,
  output div_ctl_t         ctl_out,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DM_W-1:0]  divisor,
  output logic [DVD_W-1:0] quotient
);

  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DM_W-1:0]  rem_r, rem_nxt;
  logic [DM_W-1:0]  dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DM_W:0]    trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[DVD_W-1]};
    if (ctl_in.start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = DM_W'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DM_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quotient      = quo_r;
  assign ctl_out.done  = done_r;
  assign ctl_out.start = busy_r;

endmodule

// ===== design/polyline_window_clipper_unit.sv =====
// Polyline window clipper: one vertex in, at most one clipped segment out.
// A vertex that needs no clipping passes through S_START and S_EMIT only; each edge crossing tried
// runs S_EDGE, S_DIV_GO, S_DIV_WAIT and S_CHECK (34-bit shared divider, one bit a
// cycle), each edge skipped just S_EDGE; at most two tries per end, four per vertex.
// No new vertex is taken until the last is done; divider and output stalls set the pace.
// Synchronous active-low reset: window 0,0,640x480, no previous vertex, output empty.
module polyline_window_clipper_unit import pwc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  pwc_in_if.sink    in_ch,
  pwc_out_if.source out_ch,
  pwc_cfg_if.sink   cfg_ch
);

  pwc_state_t state_r, state_nxt;

  logic signed [WIN_W-1:0]      win_left_r, win_top_r;
  logic [SIZE_W-1:0]            win_width_r, win_height_r;
  logic signed [COORD_BITS-1:0] prev_x_r, prev_y_r, cur_x_r, cur_y_r;
  logic                         prev_valid_r, first_r;
  logic                         end_r, end_nxt;
  logic [1:0]                   edge_r, edge_nxt;
  logic [3:0]                   rg_a_r, rg_a_nxt, rg_b_r, rg_b_nxt;
  logic signed [COORD_BITS-1:0] ax_r, ax_nxt, ay_r, ay_nxt, bx_r, bx_nxt, by_r, by_nxt;
  logic [DVD_W-1:0]             prod_r, prod_nxt;
  logic [DM_W-1:0]              den_r, den_nxt;
  logic                         neg_r, neg_nxt;
  logic                         out_valid_r;
  logic signed [COORD_BITS-1:0] ox0_r, oy0_r, ox1_r, oy1_r;
  logic                         load_out, upd_prev;

  logic signed [EXT_W-1:0]  xmin, xmax, ymin, ymax, edge_v, lo, hi;
  logic signed [COORD_BITS-1:0] p_x, p_y, o_x, o_y, p_other;
  logic signed [D_W-1:0]    dx, dy, num, den;
  logic signed [DIFF_W-1:0] diff;
  logic [DM_W-1:0]          num_mag, den_mag;
  logic [DFM_W-1:0]         diff_mag;
  logic [3:0]               r0, r1, rg_cur;
  logic                     applicable, in_rng;
  logic signed [T_W-1:0]    q_s, t;
  logic [DVD_W-1:0]         quo;
  div_ctl_t                 div_in, div_out;

  assign xmin = EXT_W'(win_left_r);
  assign ymin = EXT_W'(win_top_r);
  assign xmax = xmin + $signed({{(EXT_W-SIZE_W){1'b0}}, win_width_r}) - EXT_W'(1);
  assign ymax = ymin + $signed({{(EXT_W-SIZE_W){1'b0}}, win_height_r}) - EXT_W'(1);

  assign r0 = region_of(EXT_W'(prev_x_r), EXT_W'(prev_y_r), xmin, xmax, ymin, ymax);
  assign r1 = region_of(EXT_W'(cur_x_r), EXT_W'(cur_y_r), xmin, xmax, ymin, ymax);

  // End under clipping and its opposite end, both at original positions.
  assign p_x    = end_r ? cur_x_r : prev_x_r;
  assign p_y    = end_r ? cur_y_r : prev_y_r;
  assign o_x    = end_r ? prev_x_r : cur_x_r;
  assign o_y    = end_r ? prev_y_r : cur_y_r;
  assign rg_cur = end_r ? rg_b_r : rg_a_r;
  assign dx     = D_W'(o_x) - D_W'(p_x);
  assign dy     = D_W'(o_y) - D_W'(p_y);

  always_comb begin
    unique case (edge_r)
      2'd0: edge_v = xmin;
      2'd1: edge_v = xmax;
      2'd2: edge_v = ymin;
      default: edge_v = ymax;
    endcase
  end

  assign diff    = DIFF_W'(edge_v) - DIFF_W'(edge_r[1] ? p_y : p_x);
  assign num     = edge_r[1] ? dx : dy;
  assign den     = edge_r[1] ? dy : dx;
  assign p_other = edge_r[1] ? p_x : p_y;
  assign lo      = edge_r[1] ? xmin : ymin;
  assign hi      = edge_r[1] ? xmax : ymax;
  assign num_mag  = DM_W'(num[D_W-1] ? -num : num);
  assign den_mag  = DM_W'(den[D_W-1] ? -den : den);
  assign diff_mag = DFM_W'(diff[DIFF_W-1] ? -diff : diff);
  assign applicable = rg_cur[edge_r] && (den != '0);

  assign q_s    = T_W'(quo);
  assign t      = T_W'(p_other) + (neg_r ? -q_s : q_s);
  assign in_rng = (t >= T_W'(lo)) && (t <= T_W'(hi));

  pwc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_in   (div_in),
    .ctl_out  (div_out),
    .dividend (prod_r),
    .divisor  (den_r),
    .quotient (quo)
  );

  always_comb begin
    state_nxt  = state_r;
    end_nxt    = end_r;
    edge_nxt   = edge_r;
    rg_a_nxt   = rg_a_r;
    rg_b_nxt   = rg_b_r;
    ax_nxt     = ax_r;
    ay_nxt     = ay_r;
    bx_nxt     = bx_r;
    by_nxt     = by_r;
    prod_nxt   = prod_r;
    den_nxt    = den_r;
    neg_nxt    = neg_r;
    upd_prev   = 1'b0;
    load_out   = 1'b0;
    div_in     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) state_nxt = S_START;
      end
      S_START: begin
        ax_nxt = prev_x_r;
        ay_nxt = prev_y_r;
        bx_nxt = cur_x_r;
        by_nxt = cur_y_r;
        rg_a_nxt = r0;
        rg_b_nxt = r1;
        end_nxt  = (r0 == '0);
        edge_nxt = '0;
        if (first_r || !prev_valid_r || ((r0 & r1) != '0)) begin
          upd_prev  = 1'b1;
          state_nxt = S_IDLE;
        end else if ((r0 | r1) == '0) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_EDGE;
        end
      end
      S_EDGE: begin
        prod_nxt = num_mag * diff_mag;
        den_nxt  = den_mag;
        neg_nxt  = num[D_W-1] ^ diff[DIFF_W-1] ^ den[D_W-1];
        if (applicable) begin
          state_nxt = S_DIV_GO;
        end else if (edge_r == 2'd3) begin
          upd_prev  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          edge_nxt = edge_r + 2'd1;
        end
      end
      S_DIV_GO: begin
        div_in.start = 1'b1;
        state_nxt    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_out.done) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (in_rng) begin
          if (end_r) begin
            bx_nxt = edge_r[1] ? t[COORD_BITS-1:0] : edge_v[COORD_BITS-1:0];
            by_nxt = edge_r[1] ? edge_v[COORD_BITS-1:0] : t[COORD_BITS-1:0];
            state_nxt = S_EMIT;
          end else begin
            ax_nxt = edge_r[1] ? t[COORD_BITS-1:0] : edge_v[COORD_BITS-1:0];
            ay_nxt = edge_r[1] ? edge_v[COORD_BITS-1:0] : t[COORD_BITS-1:0];
            if (rg_b_r != '0) begin
              end_nxt   = 1'b1;
              edge_nxt  = '0;
              state_nxt = S_EDGE;
            end else begin
              state_nxt = S_EMIT;
            end
          end
        end else if (edge_r == 2'd3) begin
          upd_prev  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          edge_nxt  = edge_r + 2'd1;
          state_nxt = S_EDGE;
        end
      end
      S_EMIT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          upd_prev  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    end_r  <= end_nxt;
    edge_r <= edge_nxt;
    rg_a_r <= rg_a_nxt;
    rg_b_r <= rg_b_nxt;
    ax_r   <= ax_nxt;
    ay_r   <= ay_nxt;
    bx_r   <= bx_nxt;
    by_r   <= by_nxt;
    prod_r <= prod_nxt;
    den_r  <= den_nxt;
    neg_r  <= neg_nxt;
    if (in_ch.valid && in_ch.ready) begin
      cur_x_r <= in_ch.pt_x;
      cur_y_r <= in_ch.pt_y;
      first_r <= in_ch.first_point;
    end
    if (load_out) begin
      ox0_r <= ax_r;
      oy0_r <= ay_r;
      ox1_r <= bx_r;
      oy1_r <= by_r;
    end
    if (!rst_n) begin
      state_r      <= S_IDLE;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      prev_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      win_left_r   <= '0;
      win_top_r    <= '0;
      win_width_r  <= WIDTH_RST;
      win_height_r <= HEIGHT_RST;
    end else begin
      state_r <= state_nxt;
      if (upd_prev) begin
        prev_x_r     <= cur_x_r;
        prev_y_r     <= cur_y_r;
        prev_valid_r <= 1'b1;
      end
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      if (cfg_ch.valid) begin
        unique case (cfg_reg_t'(cfg_ch.index))
          CFG_WIN_LEFT:   win_left_r   <= cfg_ch.data;
          CFG_WIN_TOP:    win_top_r    <= cfg_ch.data;
          CFG_WIN_WIDTH:  win_width_r  <= cfg_ch.data[SIZE_W-1:0];
          CFG_WIN_HEIGHT: win_height_r <= cfg_ch.data[SIZE_W-1:0];
        endcase
      end
    end
  end

  assign in_ch.ready   = (state_r == S_IDLE);
  assign cfg_ch.ready  = 1'b1;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.seg_x0 = ox0_r;
  assign out_ch.seg_y0 = oy0_r;
  assign out_ch.seg_x1 = ox1_r;
  assign out_ch.seg_y1 = oy1_r;

endmodule

// ===== design/pwc_checker.sv =====
// Port-level checker for the clipper, bound to the top level.
// Depends on pwc_pkg and polyline_window_clipper_unit_assert.svh.
`include "polyline_window_clipper_unit_assert.svh"

module pwc_checker import pwc_pkg::*; (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [COORD_BITS-1:0] out_x0,
  input logic signed [COORD_BITS-1:0] out_y0,
  input logic signed [COORD_BITS-1:0] out_x1,
  input logic signed [COORD_BITS-1:0] out_y1
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // a vertex occupies the unit: no back-to-back accept
  `PWC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_acc, !in_ready)
  // a new segment is only posted while a vertex is being worked
  `PWC_ASSERT_NOW(a_result_while_busy, clk, rst_n, $rose(out_valid), $past(!in_ready))
  `PWC_ASSERT_NEXT(a_out_valid_holds, clk, rst_n, out_valid && !out_ready, out_valid)
  `PWC_ASSERT_NEXT(a_out_data_holds, clk, rst_n, out_valid && !out_ready,
    $stable(out_x0) && $stable(out_y0) && $stable(out_x1) && $stable(out_y1))

endmodule

bind polyline_window_clipper_unit pwc_checker u_pwc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_x0    (out_ch.seg_x0),
  .out_y0    (out_ch.seg_y0),
  .out_x1    (out_ch.seg_x1),
  .out_y1    (out_ch.seg_y1)
);

// ===== tb/sv/pwc_clip_checker.sv =====
// Checker for the polyline window clipper: watches the vertex, segment and
// window-register channels, predicts clipped segments and compares them.
// Depends on pwc_pkg and the three channel interfaces.
module pwc_clip_checker import pwc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  pwc_in_if    in_ch,
  pwc_out_if   out_ch,
  pwc_cfg_if   cfg_ch,
  output int   errors,
  output int   pending,
  output int   segs_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [COORD_BITS-1:0] x0, y0, x1, y1;
  } segment_t;

  segment_t seg_q[$];

  longint win_l, win_t, win_w, win_h;
  longint last_x, last_y;
  bit     last_valid;

  initial begin
    errors     = 0;
    segs_seen  = 0;
    win_l      = 0;
    win_t      = 0;
    win_w      = 640;
    win_h      = 480;
    last_x     = 0;
    last_y     = 0;
    last_valid = 0;
  end

  assign pending = seg_q.size();

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 20) $display("%0t mismatch: %s", $realtime, what);
  endtask

  function automatic logic [3:0] region_code(input longint x, input longint y);
    logic [3:0] r;
    r = '0;
    if (x < win_l) r[RG_LEFT] = 1'b1;
    else if (x > win_l + win_w - 1) r[RG_RIGHT] = 1'b1;
    if (y < win_t) r[RG_ABOVE] = 1'b1;
    else if (y > win_t + win_h - 1) r[RG_BELOW] = 1'b1;
    return r;
  endfunction

  // Move one end to its first edge crossing on the window; signed / truncates.
  function automatic bit move_to_edge(inout longint px, inout longint py,
                                      input logic [3:0] rg,
                                      input longint ox, input longint oy);
    longint xmin, xmax, ymin, ymax, x0, y0, dx, dy, t;
    xmin = win_l;
    xmax = win_l + win_w - 1;
    ymin = win_t;
    ymax = win_t + win_h - 1;
    x0 = px;
    y0 = py;
    dx = ox - x0;
    dy = oy - y0;
    if (dx != 0) begin
      if (rg[RG_LEFT]) begin
        t = y0 + (dy * (xmin - x0)) / dx;
        if (t >= ymin && t <= ymax) begin
          px = xmin; py = t; return 1'b1;
        end
      end
      if (rg[RG_RIGHT]) begin
        t = y0 + (dy * (xmax - x0)) / dx;
        if (t >= ymin && t <= ymax) begin
          px = xmax; py = t; return 1'b1;
        end
      end
    end
    if (dy != 0) begin
      if (rg[RG_ABOVE]) begin
        t = x0 + (dx * (ymin - y0)) / dy;
        if (t >= xmin && t <= xmax) begin
          px = t; py = ymin; return 1'b1;
        end
      end
      if (rg[RG_BELOW]) begin
        t = x0 + (dx * (ymax - y0)) / dy;
        if (t >= xmin && t <= xmax) begin
          px = t; py = ymax; return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  task automatic predict_segment(input longint x, input longint y, input bit fp);
    logic [3:0] r0, r1;
    longint ax, ay, bx, by;
    bit ok;
    segment_t s;
    r1 = region_code(x, y);
    if (!fp && last_valid) begin
      r0 = region_code(last_x, last_y);
      ax = last_x; ay = last_y; bx = x; by = y;
      ok = 1'b0;
      if ((r0 | r1) == 4'b0) ok = 1'b1;
      else if ((r0 & r1) == 4'b0) begin
        ok = 1'b1;
        if (r0 != 4'b0) ok = move_to_edge(ax, ay, r0, x, y);
        if (ok && r1 != 4'b0) ok = move_to_edge(bx, by, r1, last_x, last_y);
      end
      if (ok) begin
        s.x0 = ax[COORD_BITS-1:0];
        s.y0 = ay[COORD_BITS-1:0];
        s.x1 = bx[COORD_BITS-1:0];
        s.y1 = by[COORD_BITS-1:0];
        seg_q.push_back(s);
      end
    end
    last_x = x;
    last_y = y;
    last_valid = 1'b1;
  endtask

  always @(posedge clk) begin
    segment_t e;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_reg_t'(cfg_ch.index))
          CFG_WIN_LEFT:   win_l = longint'($signed(cfg_ch.data));
          CFG_WIN_TOP:    win_t = longint'($signed(cfg_ch.data));
          CFG_WIN_WIDTH:  win_w = longint'(cfg_ch.data[SIZE_W-1:0]);
          CFG_WIN_HEIGHT: win_h = longint'(cfg_ch.data[SIZE_W-1:0]);
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        segs_seen++;
        if (seg_q.size() == 0) begin
          report_mismatch($sformatf("unexpected segment (%0d,%0d)-(%0d,%0d)",
            out_ch.seg_x0, out_ch.seg_y0, out_ch.seg_x1, out_ch.seg_y1));
        end else begin
          e = seg_q.pop_front();
          if (out_ch.seg_x0 !== e.x0 || out_ch.seg_y0 !== e.y0 ||
              out_ch.seg_x1 !== e.x1 || out_ch.seg_y1 !== e.y1)
            report_mismatch($sformatf("segment (%0d,%0d)-(%0d,%0d) expected (%0d,%0d)-(%0d,%0d)",
              out_ch.seg_x0, out_ch.seg_y0, out_ch.seg_x1, out_ch.seg_y1,
              e.x0, e.y0, e.x1, e.y1));
        end
      end
      if (in_ch.valid && in_ch.ready)
        predict_segment(longint'(in_ch.pt_x), longint'(in_ch.pt_y), in_ch.first_point);
    end
  end
endmodule

// ===== tb/sv/testbench.sv =====
// Top of the clipper testbench: clock, reset, vertex and window stimulus,
// receiver back-pressure, watchdog and verdict. Depends on pwc_pkg, the
// channel interfaces, pwc_clip_checker and polyline_window_clipper_unit.
module testbench;
  import pwc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 400;

  logic clk;
  logic rst_n;
  int   errors, pending, segs_seen;
  int   send_idle_pct, recv_idle_pct, hold_cycles;
  int   vertices_sent, quiet_cycles;

  pwc_in_if  in_ch();
  pwc_out_if out_ch();
  pwc_cfg_if cfg_ch();

  polyline_window_clipper_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  pwc_clip_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .errors(errors), .pending(pending), .segs_seen(segs_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready = 1'b0;
        hold_cycles--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic send_vertex(input logic [15:0] x, input logic [15:0] y, input bit fp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.pt_x        = x;
    in_ch.pt_y        = y;
    in_ch.first_point = fp;
    do @(posedge clk); while (!in_ch.ready);
    vertices_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] d);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = d;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Hold the sender until all segments are out and the block has gone quiet.
  task automatic drain();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_window(input int l, input int t, input int w, input int h);
    drain();
    write_reg(CFG_WIN_LEFT, 16'(l));
    write_reg(CFG_WIN_TOP, 16'(t));
    write_reg(CFG_WIN_WIDTH, {1'($urandom_range(1)), 15'(w)});
    write_reg(CFG_WIN_HEIGHT, {1'($urandom_range(1)), 15'(h)});
  endtask

  // Mostly near the window span, sometimes anywhere in the 16-bit range.
  function automatic logic [15:0] pick_coord(input int lo, input int span);
    int v;
    if ($urandom_range(9) == 0) return 16'($urandom);
    v = lo - 64 + $urandom_range(span + 127);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  int win_list[8][4] = '{
    '{0, 0, 640, 480}, '{-32768, -32768, 32767, 32767}, '{32767, 32767, 1, 1},
    '{-20, -30, 1, 1}, '{100, -200, 32767, 5}, '{-32768, 0, 1, 32767},
    '{1000, -1000, 300, 200}, '{-5, 7, 64, 48}
  };

  int directed[16][3] = '{
    '{100, 100, 1}, '{200, 150, 0}, '{-32768, -32768, 0}, '{32767, 32767, 0},
    '{32767, -32768, 0}, '{300, -32768, 1}, '{300, 32767, 0}, '{-32768, 200, 1},
    '{32767, 200, 0}, '{-10, -10, 1}, '{700, 500, 0}, '{-50, 300, 0},
    '{100, -50, 0}, '{0, 0, 0}, '{639, 479, 0}, '{-1, 480, 0}
  };

  initial begin
    int w, run, span_x, span_y;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.pt_x = '0;
    in_ch.pt_y = '0;
    in_ch.first_point = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_WIN_LEFT;
    cfg_ch.data = '0;
    send_idle_pct = 32;
    recv_idle_pct = 51;
    hold_cycles = 0;
    vertices_sent = 0;
    quiet_cycles = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Extremes, vertical and horizontal crossings, trivial accept and reject.
    foreach (directed[i])
      send_vertex(16'(directed[i][0]), 16'(directed[i][1]), directed[i][2] != 0);
    // Window moves between two vertices of one polyline.
    set_window(-100, 50, 200, 100);
    send_vertex(16'(50), 16'(500), 1'b0);
    send_vertex(16'(-300), 16'(-300), 1'b0);

    for (w = 0; w < 8; w++) begin
      if (w == 3) begin
        send_idle_pct = 51;
        recv_idle_pct = 32;
      end else if (w == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_window(win_list[w][0], win_list[w][1], win_list[w][2], win_list[w][3]);
      span_x = win_list[w][2];
      span_y = win_list[w][3];
      if (w == 7) hold_cycles = 600;
      run = 0;
      repeat (250) begin
        if (run == 0) run = $urandom_range(12, 1);
        send_vertex(pick_coord(win_list[w][0], span_x), pick_coord(win_list[w][1], span_y),
                    (run == 1 && $urandom_range(1) == 1) || $urandom_range(19) == 0);
        run--;
      end
    end

    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Covered %0d vertices over 9 window settings, %0d clipped segments checked.",
             vertices_sent, segs_seen);
    $display("Included full-range, unit-size and edge windows with stalls on both sides.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
